### hw/rtl/mp2d_pkg.sv
// Shared constants, register codes and configuration type for the 2-D max pooling block.
package mp2d_pkg;

   // Default sizes of the line store and sample path
   localparam int MAX_WIDTH_DEF   = 64;
   localparam int MAX_WINDOW_DEF  = 4;
   localparam int SAMPLE_BITS_DEF = 16;

   // Fixed field widths
   localparam int W_BITS         = 7;
   localparam int ROW_BITS       = 12;
   localparam int WIN_BITS       = 3;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 12;

   // Register reset values
   localparam logic [W_BITS-1:0]   RST_IMAGE_WIDTH  = 7'd64;
   localparam logic [ROW_BITS-1:0] RST_IMAGE_HEIGHT = 12'd64;
   localparam logic [WIN_BITS-1:0] RST_WINDOW_ROWS  = 3'd2;
   localparam logic [WIN_BITS-1:0] RST_WINDOW_COLS  = 3'd2;
   localparam logic                RST_STRIDE_MODE  = 1'b0;

   // Register indexes on the csr port
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_IMAGE_WIDTH  = 3'd0,
      CSR_IMAGE_HEIGHT = 3'd1,
      CSR_WINDOW_ROWS  = 3'd2,
      CSR_WINDOW_COLS  = 3'd3,
      CSR_STRIDE_MODE  = 3'd4
   } csr_index_type;

   // Effective (range-limited) configuration
   typedef struct packed {
      logic [W_BITS-1:0]   width;
      logic [ROW_BITS-1:0] height;
      logic [WIN_BITS-1:0] win_rows;
      logic [WIN_BITS-1:0] win_cols;
      logic                stride_step;
   } cfg_type;

endpackage

### hw/rtl/mp2d_csr.sv
// Configuration registers with range limiting of the image and window sizes.
module mp2d_csr
   import mp2d_pkg::*;
#(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   output cfg_type                   cfg
);

   logic [W_BITS-1:0]   width_ff,    width_in;
   logic [ROW_BITS-1:0] height_ff,   height_in;
   logic [WIN_BITS-1:0] win_rows_ff, win_rows_in;
   logic [WIN_BITS-1:0] win_cols_ff, win_cols_in;
   logic                mode_ff,     mode_in;
   csr_index_type       index;

   assign index = csr_index_type'(csr_index);

   // Decode the write
   always_comb begin
      width_in    = width_ff;
      height_in   = height_ff;
      win_rows_in = win_rows_ff;
      win_cols_in = win_cols_ff;
      mode_in     = mode_ff;
      if (csr_wr_en) begin
         unique case (index)
            CSR_IMAGE_WIDTH:  width_in    = csr_wdata[W_BITS-1:0];
            CSR_IMAGE_HEIGHT: height_in   = csr_wdata[ROW_BITS-1:0];
            CSR_WINDOW_ROWS:  win_rows_in = csr_wdata[WIN_BITS-1:0];
            CSR_WINDOW_COLS:  win_cols_in = csr_wdata[WIN_BITS-1:0];
            CSR_STRIDE_MODE:  mode_in     = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= RST_IMAGE_WIDTH;
         height_ff   <= RST_IMAGE_HEIGHT;
         win_rows_ff <= RST_WINDOW_ROWS;
         win_cols_ff <= RST_WINDOW_COLS;
         mode_ff     <= RST_STRIDE_MODE;
      end else begin
         width_ff    <= width_in;
         height_ff   <= height_in;
         win_rows_ff <= win_rows_in;
         win_cols_ff <= win_cols_in;
         mode_ff     <= mode_in;
      end
   end

   // Limit sizes: zero acts as one, oversize width or window acts as the maximum
   always_comb begin
      if (width_ff == '0) begin
         cfg.width = W_BITS'(1);
      end else if (int'(width_ff) > MAX_WIDTH) begin
         cfg.width = W_BITS'(MAX_WIDTH);
      end else begin
         cfg.width = width_ff;
      end

      cfg.height = (height_ff == '0) ? ROW_BITS'(1) : height_ff;

      if (win_rows_ff == '0) begin
         cfg.win_rows = WIN_BITS'(1);
      end else if (int'(win_rows_ff) > MAX_WINDOW) begin
         cfg.win_rows = WIN_BITS'(MAX_WINDOW);
      end else begin
         cfg.win_rows = win_rows_ff;
      end

      if (win_cols_ff == '0) begin
         cfg.win_cols = WIN_BITS'(1);
      end else if (int'(win_cols_ff) > MAX_WINDOW) begin
         cfg.win_cols = WIN_BITS'(MAX_WINDOW);
      end else begin
         cfg.win_cols = win_cols_ff;
      end

      cfg.stride_step = mode_ff;
   end

endmodule

### hw/rtl/mp2d_div_small.sv
// Exact quotient of a counter by a small window size, by multiplication with a reciprocal.
module mp2d_div_small
   import mp2d_pkg::*;
#(
   parameter int X_BITS  = ROW_BITS,
   parameter int MAX_DIV = MAX_WINDOW_DEF
) (
   input  logic [X_BITS-1:0]   dividend,
   input  logic [WIN_BITS-1:0] divisor,
   output logic [X_BITS-1:0]   quotient
);

   localparam int SHIFT    = X_BITS + $clog2(MAX_DIV);
   localparam int M_BITS   = SHIFT + 1;
   localparam int P_BITS   = X_BITS + M_BITS;
   localparam int IDX_BITS = (MAX_DIV > 2) ? $clog2(MAX_DIV) : 1;

   logic [M_BITS-1:0]   recip [MAX_DIV];
   logic [WIN_BITS-1:0] div_m1;
   logic [IDX_BITS-1:0] idx;
   logic [P_BITS-1:0]   prod;

   // ceil(2^SHIFT / d) is exact for every dividend below 2^X_BITS
   for (genvar g = 0; g < MAX_DIV; g++) begin : g_recip
      localparam longint unsigned RECIP = ((64'd1 << SHIFT) + g) / (g + 1);
      assign recip[g] = M_BITS'(RECIP);
   end

   assign div_m1   = divisor - WIN_BITS'(1);
   assign idx      = div_m1[IDX_BITS-1:0];
   assign prod     = P_BITS'(dividend) * P_BITS'(recip[idx]);
   assign quotient = prod[SHIFT +: X_BITS];

endmodule

### hw/rtl/mp2d_line_bank.sv
// One row of the line store: single address port, registered read.
module mp2d_line_bank #(
   parameter int DATA_BITS = 16,
   parameter int DEPTH     = 64
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic                         rd_en,
   input  logic [$clog2(DEPTH)-1:0]     addr,
   input  logic signed [DATA_BITS-1:0]  wr_data,
   output logic signed [DATA_BITS-1:0]  rd_data
);

   logic signed [DATA_BITS-1:0] mem [DEPTH];
   logic signed [DATA_BITS-1:0] rd_data_ff;

   // Read returns the old word when the same entry is written
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/max_pool_2d_window_core.sv
// Top level of the streaming 2-D max pooling block.
//
// Usage: samples enter in raster order on the req_ channel (valid/ready), one
// word per clock when the output side keeps up. Each accepted word that
// completes a pooling window produces one rsp_ word carrying the window
// maximum, its row and column in the pooled matrix, and a frame_last flag on
// the final result of the frame; other words produce nothing.
// A result passes from stage 1 through stage 2 into the output register.
// Throughput: one sample per cycle while the output side keeps up, set by the
// single-port row banks being read and written once per accepted word.
// The csr_ port writes image width/height, window rows/cols and stride mode;
// write only while no word is in flight. Changes apply to the next sample,
// row/column counters are kept.
// Reset clears the counters, the pipeline valids, the column max shift
// register and the configuration to its defaults. Line store contents are not
// cleared; the first rows of a frame overwrite them before use.
// When rsp_ready is low and a result waits, words without a result still drain
// through; req_ready drops once stage 1 also fills behind a blocked result.
module max_pool_2d_window_core
   import mp2d_pkg::*;
#(
   parameter  int MAX_WIDTH   = MAX_WIDTH_DEF,
   parameter  int MAX_WINDOW  = MAX_WINDOW_DEF,
   parameter  int SAMPLE_BITS = SAMPLE_BITS_DEF,
   localparam int COL_BITS    = $clog2(MAX_WIDTH)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [CSR_DATA_BITS-1:0]      csr_wdata,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_pixel_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_pooled_value,
   output logic [ROW_BITS-1:0]           rsp_out_row,
   output logic [COL_BITS-1:0]           rsp_out_col,
   output logic                          rsp_frame_last
);

   localparam int STORE_ROWS = MAX_WINDOW - 1;
   localparam int SLOT_BITS  = (STORE_ROWS > 1) ? $clog2(STORE_ROWS) : 1;
   localparam int CW         = (COL_BITS + 1 > W_BITS) ? COL_BITS + 1 : W_BITS;
   localparam int CW1        = CW + 1;
   localparam int RW         = ROW_BITS + 1;
   localparam int DW         = ((SLOT_BITS > WIN_BITS) ? SLOT_BITS : WIN_BITS) + 1;

   cfg_type cfg;

   // Handshake and pipeline control
   logic accept;
   logic out_free, s1_go, s2_go, s2_free;
   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic rsp_valid_ff, rsp_valid_in;

   // Position counters
   logic [COL_BITS-1:0]  col_ff,  col_in;
   logic [ROW_BITS-1:0]  row_ff,  row_in;
   logic [SLOT_BITS-1:0] slot_ff, slot_in;
   logic [COL_BITS-1:0]  mem_addr;
   logic [ROW_BITS-1:0]  row_q;
   logic [COL_BITS-1:0]  col_q;
   logic [STORE_ROWS-1:0] take_in;

   // Stage 1
   logic signed [SAMPLE_BITS-1:0] s1_pixel_ff, s1_pixel_in;
   logic [ROW_BITS-1:0]           s1_row_ff,   s1_row_in;
   logic [COL_BITS-1:0]           s1_col_ff,   s1_col_in;
   logic [ROW_BITS-1:0]           s1_row_q_ff, s1_row_q_in;
   logic [COL_BITS-1:0]           s1_col_q_ff, s1_col_q_in;
   logic [STORE_ROWS-1:0]         s1_take_ff,  s1_take_in;
   logic signed [SAMPLE_BITS-1:0] bank_data [STORE_ROWS];
   logic signed [SAMPLE_BITS-1:0] colmax;
   logic                          emit;
   logic [ROW_BITS-1:0]           orow;
   logic [COL_BITS-1:0]           ocol;
   logic                          last;

   // Stage 2
   logic signed [SAMPLE_BITS-1:0] shift_ff [MAX_WINDOW];
   logic signed [SAMPLE_BITS-1:0] shift_in [MAX_WINDOW];
   logic                          s2_emit_ff, s2_emit_in;
   logic [ROW_BITS-1:0]           s2_row_ff,  s2_row_in;
   logic [COL_BITS-1:0]           s2_col_ff,  s2_col_in;
   logic                          s2_last_ff, s2_last_in;
   logic signed [SAMPLE_BITS-1:0] winmax;

   // Output register
   logic signed [SAMPLE_BITS-1:0] rsp_value_ff, rsp_value_in;
   logic [ROW_BITS-1:0]           rsp_row_ff,   rsp_row_in;
   logic [COL_BITS-1:0]           rsp_col_ff,   rsp_col_in;
   logic                          rsp_last_ff,  rsp_last_in;

   mp2d_csr #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_WINDOW (MAX_WINDOW)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Flow control: a stage moves when the one after it is free or moving; a stage 2 word with no result need not wait
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s2_go     = s2_valid_ff && (!s2_emit_ff || out_free);
   assign s2_free   = !s2_valid_ff || s2_go;
   assign s1_go     = s1_valid_ff && s2_free;
   assign req_ready = !s1_valid_ff || s1_go;
   assign accept    = req_valid && req_ready;

   // Advance column, row and line store slot on each accepted word
   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      slot_in = slot_ff;
      if (accept) begin
         if (CW'(col_ff) + CW'(1) >= CW'(cfg.width)) begin
            col_in = '0;
            if (RW'(row_ff) + RW'(1) >= RW'(cfg.height)) begin
               row_in  = '0;
               slot_in = '0;
            end else begin
               row_in  = row_ff + ROW_BITS'(1);
               slot_in = (slot_ff == SLOT_BITS'(STORE_ROWS - 1)) ? '0
                                                                 : slot_ff + SLOT_BITS'(1);
            end
         end else begin
            col_in = col_ff + COL_BITS'(1);
         end
      end
   end

   assign mem_addr = (int'(col_ff) > MAX_WIDTH - 1) ? COL_BITS'(MAX_WIDTH - 1) : col_ff;

   // Select the banks that hold the window's older rows; the bank of the
   // current slot still holds the row a full store depth back until this word
   // overwrites it
   always_comb begin
      logic [DW-1:0] row_gap;
      row_gap = '0;
      for (int b = 0; b < STORE_ROWS; b++) begin
         if (DW'(slot_ff) >= DW'(b)) begin
            row_gap = DW'(slot_ff) - DW'(b);
         end else begin
            row_gap = DW'(slot_ff) + DW'(STORE_ROWS) - DW'(b);
         end
         if (row_gap == '0) begin
            row_gap = DW'(STORE_ROWS);
         end
         take_in[b] = row_gap < DW'(cfg.win_rows);
      end
   end

   for (genvar b = 0; b < STORE_ROWS; b++) begin : g_bank
      mp2d_line_bank #(
         .DATA_BITS (SAMPLE_BITS),
         .DEPTH     (MAX_WIDTH)
      ) u_bank (
         .clock   (clock),
         .wr_en   (accept && (slot_ff == SLOT_BITS'(b))),
         .rd_en   (accept),
         .addr    (mem_addr),
         .wr_data (req_pixel_value),
         .rd_data (bank_data[b])
      );
   end

   mp2d_div_small #(
      .X_BITS  (ROW_BITS),
      .MAX_DIV (MAX_WINDOW)
   ) u_row_div (
      .dividend (row_ff),
      .divisor  (cfg.win_rows),
      .quotient (row_q)
   );

   mp2d_div_small #(
      .X_BITS  (COL_BITS),
      .MAX_DIV (MAX_WINDOW)
   ) u_col_div (
      .dividend (col_ff),
      .divisor  (cfg.win_cols),
      .quotient (col_q)
   );

   // Stage 1 load
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_pixel_in = s1_pixel_ff;
      s1_row_in   = s1_row_ff;
      s1_col_in   = s1_col_ff;
      s1_row_q_in = s1_row_q_ff;
      s1_col_q_in = s1_col_q_ff;
      s1_take_in  = s1_take_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
         s1_pixel_in = req_pixel_value;
         s1_row_in   = row_ff;
         s1_col_in   = col_ff;
         s1_row_q_in = row_q;
         s1_col_q_in = col_q;
         s1_take_in  = take_in;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end
   end

   // Column maximum over the window's rows
   always_comb begin
      colmax = s1_pixel_ff;
      for (int b = 0; b < STORE_ROWS; b++) begin
         if (s1_take_ff[b] && (bank_data[b] > colmax)) begin
            colmax = bank_data[b];
         end
      end
   end

   // Decide whether this word completes a window, and where the result goes
   always_comb begin
      logic [ROW_BITS-1:0] rem_r;
      logic [CW-1:0]       rem_c;
      logic                fits;
      rem_r = s1_row_ff - ROW_BITS'(s1_row_q_ff * ROW_BITS'(cfg.win_rows));
      rem_c = CW'(s1_col_ff) - CW'(CW'(s1_col_q_ff) * CW'(cfg.win_cols));
      fits  = (RW'(s1_row_ff) + RW'(1) >= RW'(cfg.win_rows))
           && (CW'(s1_col_ff) + CW'(1) >= CW'(cfg.win_cols))
           && (s1_row_ff < cfg.height)
           && (CW'(s1_col_ff) < CW'(cfg.width));
      if (!cfg.stride_step) begin
         emit = fits;
         orow = ROW_BITS'(RW'(s1_row_ff) + RW'(1) - RW'(cfg.win_rows));
         ocol = COL_BITS'(CW'(s1_col_ff) + CW'(1) - CW'(cfg.win_cols));
         last = (RW'(s1_row_ff) + RW'(1) == RW'(cfg.height))
             && (CW'(s1_col_ff) + CW'(1) == CW'(cfg.width));
      end else begin
         emit = fits
             && (rem_r == ROW_BITS'(cfg.win_rows - WIN_BITS'(1)))
             && (rem_c == CW'(cfg.win_cols - WIN_BITS'(1)));
         orow = s1_row_q_ff;
         ocol = s1_col_q_ff;
         last = (RW'(s1_row_ff) + RW'(1) + RW'(cfg.win_rows) > RW'(cfg.height))
             && (CW1'(s1_col_ff) + CW1'(1) + CW1'(cfg.win_cols) > CW1'(cfg.width));
      end
   end

   // Stage 2 load and column max shift
   always_comb begin
      s2_valid_in = s2_valid_ff;
      s2_emit_in  = s2_emit_ff;
      s2_row_in   = s2_row_ff;
      s2_col_in   = s2_col_ff;
      s2_last_in  = s2_last_ff;
      shift_in    = shift_ff;
      if (s1_go) begin
         s2_valid_in = 1'b1;
         s2_emit_in  = emit;
         s2_row_in   = orow;
         s2_col_in   = ocol;
         s2_last_in  = last;
         shift_in[0] = colmax;
         for (int k = 1; k < MAX_WINDOW; k++) begin
            shift_in[k] = shift_ff[k-1];
         end
      end else if (s2_go) begin
         s2_valid_in = 1'b0;
      end
   end

   // Window maximum over the newest columns
   always_comb begin
      winmax = shift_ff[0];
      for (int k = 1; k < MAX_WINDOW; k++) begin
         if ((k < int'(cfg.win_cols)) && (shift_ff[k] > winmax)) begin
            winmax = shift_ff[k];
         end
      end
   end

   // Output register: load a result, drop it once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_last_in  = rsp_last_ff;
      if (s2_go && s2_emit_ff) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = winmax;
         rsp_row_in   = s2_row_ff;
         rsp_col_in   = s2_col_ff;
         rsp_last_in  = s2_last_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         slot_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < MAX_WINDOW; k++) begin
            shift_ff[k] <= '0;
         end
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         slot_ff      <= slot_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         shift_ff     <= shift_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      s1_pixel_ff  <= s1_pixel_in;
      s1_row_ff    <= s1_row_in;
      s1_col_ff    <= s1_col_in;
      s1_row_q_ff  <= s1_row_q_in;
      s1_col_q_ff  <= s1_col_q_in;
      s1_take_ff   <= s1_take_in;
      s2_emit_ff   <= s2_emit_in;
      s2_row_ff    <= s2_row_in;
      s2_col_ff    <= s2_col_in;
      s2_last_ff   <= s2_last_in;
      rsp_value_ff <= rsp_value_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pooled_value = rsp_value_ff;
   assign rsp_out_row      = rsp_row_ff;
   assign rsp_out_col      = rsp_col_ff;
   assign rsp_frame_last   = rsp_last_ff;

endmodule

### hw/rtl/mp2d_checker.sv
// Port-level checks on the pooling block, bound to its top level.
module mp2d_checker
   import mp2d_pkg::*;
#(
   parameter  int MAX_WIDTH   = MAX_WIDTH_DEF,
   parameter  int SAMPLE_BITS = SAMPLE_BITS_DEF,
   localparam int COL_BITS    = $clog2(MAX_WIDTH)
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic signed [SAMPLE_BITS-1:0] rsp_pooled_value,
   input logic [ROW_BITS-1:0]           rsp_out_row,
   input logic [COL_BITS-1:0]           rsp_out_col,
   input logic                          rsp_frame_last
);

   // Reset empties the output register
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // A stalled result stays offered
   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // A stalled result keeps its word
   a_hold_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_pooled_value) && $stable(rsp_out_row)
                                  && $stable(rsp_out_col) && $stable(rsp_frame_last))
      else $error("result word changed while stalled");

   // With the output side free the block always takes a new word
   a_ready_when_free: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || rsp_ready) |-> req_ready)
      else $error("req_ready low with output free");

endmodule

bind max_pool_2d_window_core mp2d_checker #(
   .MAX_WIDTH   (MAX_WIDTH),
   .SAMPLE_BITS (SAMPLE_BITS)
) u_mp2d_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_pooled_value (rsp_pooled_value),
   .rsp_out_row      (rsp_out_row),
   .rsp_out_col      (rsp_out_col),
   .rsp_frame_last   (rsp_frame_last)
);
